// ===== rtl/lowpass_echo_audio_effect_core_defines.svh =====
// Assertion macros for the low-pass echo core checker.
// Used by lec_checker.sv; no other dependencies.
`ifndef LOWPASS_ECHO_AUDIO_EFFECT_CORE_DEFINES_SVH
`define LOWPASS_ECHO_AUDIO_EFFECT_CORE_DEFINES_SVH

// same-cycle implication, quiet during reset
`define LEC_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define LEC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// ===== rtl/lec_pkg.sv =====
// Shared types and constants for the low-pass echo core.
// No dependencies; used by every module of the block.
package lec_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ACC_W      = 25;
    localparam int SHIFT_W    = 4;
    localparam int GAIN_W     = 7;
    localparam int DELAY_W    = 13;
    localparam int PROD_W     = SAMPLE_W + GAIN_W + 1;
    localparam int MAG_W      = PROD_W - 1;
    localparam int Q_W        = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_SHIFT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_GAIN_PERCENT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ECHO_DELAY        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TWO_CHANNELS      = 2'd3;

    localparam logic [SHIFT_W-1:0] RST_LOWPASS_SHIFT = 4'd3;
    localparam logic [GAIN_W-1:0]  RST_ECHO_GAIN     = 7'd20;
    localparam logic [DELAY_W-1:0] RST_ECHO_DELAY    = 13'd0;
    localparam logic               RST_TWO_CHANNELS  = 1'b1;

    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd8;

    // floor(m / 100) = (m * RECIP_100) >> RECIP_SHIFT, exact for m below 6100806
    localparam logic [MAG_W-1:0] RECIP_100   = 23'd5368710;
    localparam int               RECIP_SHIFT = 29;

    localparam logic signed [Q_W:0] SAMPLE_MAX = 19'sd32767;
    localparam logic signed [Q_W:0] SAMPLE_MIN = -19'sd32768;

    typedef struct packed {
        logic               accept;
        logic               first;
        logic               tap_ok;
        logic               bypass;
        logic [SHIFT_W-1:0] shift;
        logic [GAIN_W-1:0]  gain;
    } t_lane_ctl;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

// ===== rtl/lec_lane.sv =====
// One channel lane: leaky integrator, echo delay memory, gain and divide-by-100.
// Depends on lec_pkg.
module lec_lane import lec_pkg::*; #(
    parameter int DELAY_DEPTH = 8192,
    localparam int AW = $clog2(DELAY_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_active,
    input  t_lane_ctl                  i_ctl,
    input  t_stage_en                  i_en,
    input  logic [AW-1:0]              i_waddr,
    input  logic [AW-1:0]              i_raddr,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic signed [SAMPLE_W-1:0] o_filt,
    output logic signed [Q_W-1:0]      o_echo
);

    logic signed [ACC_W-1:0]    r_acc;
    logic [SAMPLE_W-1:0]        r_mem [DELAY_DEPTH];

    logic signed [SAMPLE_W-1:0] r_rd1, r_x1, r_filt1;
    logic                       r_ok1, r_byp1;
    logic signed [PROD_W-1:0]   r_prod2;
    logic signed [SAMPLE_W-1:0] r_filt2;
    logic [2*MAG_W-1:0]         r_mr3;
    logic                       r_neg3;
    logic signed [SAMPLE_W-1:0] r_filt3;

    logic signed [ACC_W-1:0]    acc_base, acc_sh, n_acc;
    logic signed [SAMPLE_W-1:0] tap;
    logic signed [PROD_W-1:0]   prod;
    logic                       neg;
    logic [MAG_W-1:0]           mag;
    logic [Q_W-2:0]             quot;

    assign acc_base = i_ctl.first ? '0 : r_acc;
    assign acc_sh   = acc_base >>> i_ctl.shift;
    assign n_acc    = acc_base - acc_sh + ACC_W'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.accept) begin
            if (i_active) begin
                r_acc <= n_acc;
            end else if (i_ctl.first) begin
                r_acc <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_active) begin
            r_mem[i_waddr] <= i_sample;
        end
        if (i_en.s1) begin
            r_rd1   <= r_mem[i_raddr];
            r_x1    <= i_sample;
            r_filt1 <= acc_sh[SAMPLE_W-1:0];
            r_ok1   <= i_ctl.tap_ok;
            r_byp1  <= i_ctl.bypass;
        end
    end

    assign tap  = !r_ok1 ? '0 : (r_byp1 ? r_x1 : r_rd1);
    assign prod = tap * $signed({1'b0, i_ctl.gain});

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod2 <= prod;
            r_filt2 <= r_filt1;
        end
    end

    assign neg = r_prod2[PROD_W-1];
    assign mag = neg ? MAG_W'(-r_prod2) : MAG_W'(r_prod2);

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_mr3   <= mag * RECIP_100;
            r_neg3  <= neg;
            r_filt3 <= r_filt2;
        end
    end

    assign quot   = r_mr3[RECIP_SHIFT +: Q_W-1];
    assign o_echo = r_neg3 ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign o_filt = r_filt3;

endmodule

// ===== rtl/lec_merge.sv =====
// Merging stage: adds echo to filter output, clamps, and holds the result item.
// Depends on lec_pkg.
module lec_merge import lec_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic                       i_two_channels,
    input  logic signed [SAMPLE_W-1:0] i_filt_l,
    input  logic signed [Q_W-1:0]      i_echo_l,
    input  logic signed [SAMPLE_W-1:0] i_filt_r,
    input  logic signed [Q_W-1:0]      i_echo_r,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_left,
    output logic signed [SAMPLE_W-1:0] o_right
);

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_left, r_right;
    logic signed [Q_W:0]        sum_l, sum_r;

    function automatic logic signed [SAMPLE_W-1:0] clamp(input logic signed [Q_W:0] v);
        logic signed [SAMPLE_W-1:0] res;
        if (v > SAMPLE_MAX) begin
            res = SAMPLE_W'(SAMPLE_MAX);
        end else if (v < SAMPLE_MIN) begin
            res = SAMPLE_W'(SAMPLE_MIN);
        end else begin
            res = v[SAMPLE_W-1:0];
        end
        return res;
    endfunction

    assign sum_l = (Q_W+1)'(i_filt_l) + (Q_W+1)'(i_echo_l);
    assign sum_r = (Q_W+1)'(i_filt_r) + (Q_W+1)'(i_echo_r);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en && i_valid) begin
            r_left  <= clamp(sum_l);
            r_right <= i_two_channels ? clamp(sum_r) : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_left  = r_left;
    assign o_right = r_right;

endmodule

// ===== rtl/lowpass_echo_audio_effect_core.sv =====
// Low-pass echo core: one item per clock unless output stalls; items pass the lane stages,
// then the merge. The rate is set by the single accumulator update per item and one write
// plus one read of each channel's delay memory per item. Two lanes (left, right) run side
// by side; the merge adds echo, clamps and holds the result; input flows until stages fill.
// Depends on lec_pkg, lec_lane, lec_merge.
module lowpass_echo_audio_effect_core import lec_pkg::*; #(
    parameter int DELAY_DEPTH = 8192
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_first_of_sound,
    input  logic signed [SAMPLE_W-1:0] i_sample_left,
    input  logic signed [SAMPLE_W-1:0] i_sample_right,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic signed [SAMPLE_W-1:0] o_out_left,
    output logic signed [SAMPLE_W-1:0] o_out_right,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam logic [AW-1:0] DEPTH_M1 = AW'(DELAY_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_X  = (AW+1)'(DELAY_DEPTH);

    logic [SHIFT_W-1:0] r_lowpass_shift;
    logic [GAIN_W-1:0]  r_echo_gain;
    logic [DELAY_W-1:0] r_echo_delay;
    logic               r_two_channels;

    logic [AW-1:0] r_wp;
    logic [AW:0]   r_sss;
    logic          r_v1, r_v2, r_v3;

    logic          en_out, accept;
    t_stage_en     en;
    t_lane_ctl     ctl;
    logic [AW-1:0] dly, raddr;
    logic [AW:0]   sss_base, n_sss;

    logic signed [SAMPLE_W-1:0] filt_l, filt_r;
    logic signed [Q_W-1:0]      echo_l, echo_r;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowpass_shift <= RST_LOWPASS_SHIFT;
            r_echo_gain     <= RST_ECHO_GAIN;
            r_echo_delay    <= RST_ECHO_DELAY;
            r_two_channels  <= RST_TWO_CHANNELS;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_LOWPASS_SHIFT:     r_lowpass_shift <= i_cfg_data[SHIFT_W-1:0];
                CFG_ECHO_GAIN_PERCENT: r_echo_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_ECHO_DELAY:        r_echo_delay    <= i_cfg_data[DELAY_W-1:0];
                CFG_TWO_CHANNELS:      r_two_channels  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // elastic stage enables, ready ripples back from the output register
    assign en_out     = !o_out_valid || i_out_ready;
    assign en.s3      = !r_v3 || en_out;
    assign en.s2      = !r_v2 || en.s3;
    assign en.s1      = !r_v1 || en.s2;
    assign o_in_ready = en.s1;
    assign accept     = i_in_valid && en.s1;

    assign dly = (32'(r_echo_delay) >= 32'(DELAY_DEPTH)) ? DEPTH_M1 : AW'(r_echo_delay);
    assign raddr = (r_wp >= dly) ? AW'(r_wp - dly)
                                 : AW'({1'b0, r_wp} + DEPTH_X - {1'b0, dly});

    assign sss_base = i_first_of_sound ? '0 : r_sss;
    assign n_sss    = (sss_base < DEPTH_X) ? sss_base + 1'b1 : sss_base;

    assign ctl.accept = accept;
    assign ctl.first  = i_first_of_sound;
    assign ctl.tap_ok = {1'b0, dly} < n_sss;
    assign ctl.bypass = (dly == '0);
    assign ctl.shift  = (r_lowpass_shift > SHIFT_MAX) ? SHIFT_MAX : r_lowpass_shift;
    assign ctl.gain   = r_echo_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_sss <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
        end else begin
            if (accept) begin
                r_wp  <= (r_wp == DEPTH_M1) ? '0 : r_wp + 1'b1;
                r_sss <= n_sss;
            end
            if (en.s1) begin
                r_v1 <= accept;
            end
            if (en.s2) begin
                r_v2 <= r_v1;
            end
            if (en.s3) begin
                r_v3 <= r_v2;
            end
        end
    end

    lec_lane #(.DELAY_DEPTH(DELAY_DEPTH)) u_lane_left (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_active (1'b1),
        .i_ctl    (ctl),
        .i_en     (en),
        .i_waddr  (r_wp),
        .i_raddr  (raddr),
        .i_sample (i_sample_left),
        .o_filt   (filt_l),
        .o_echo   (echo_l)
    );

    lec_lane #(.DELAY_DEPTH(DELAY_DEPTH)) u_lane_right (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_active (r_two_channels),
        .i_ctl    (ctl),
        .i_en     (en),
        .i_waddr  (r_wp),
        .i_raddr  (raddr),
        .i_sample (i_sample_right),
        .o_filt   (filt_r),
        .o_echo   (echo_r)
    );

    lec_merge u_merge (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (en_out),
        .i_valid        (r_v3),
        .i_two_channels (r_two_channels),
        .i_filt_l       (filt_l),
        .i_echo_l       (echo_l),
        .i_filt_r       (filt_r),
        .i_echo_r       (echo_r),
        .o_valid        (o_out_valid),
        .o_left         (o_out_left),
        .o_right        (o_out_right)
    );

endmodule

// ===== rtl/lec_checker.sv =====
// Port-level checker for the low-pass echo core, bound to the top level.
// Depends on lec_pkg and lowpass_echo_audio_effect_core_defines.svh.
`include "lowpass_echo_audio_effect_core_defines.svh"

module lec_checker import lec_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic signed [SAMPLE_W-1:0] o_out_left,
    input logic signed [SAMPLE_W-1:0] o_out_right,
    input logic                       o_cfg_ready
);

    // input only stalls when the output register is full and held
    `LEC_ASSERT_IMPLY(a_stall_cause, i_clk, i_rst_n, !o_in_ready,
        o_out_valid && !i_out_ready, "input stalled without output backpressure")

    `LEC_ASSERT_IMPLY(a_cfg_ready, i_clk, i_rst_n, 1'b1, o_cfg_ready,
        "config port not ready")

    `LEC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid, "result item dropped")

    `LEC_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        $stable(o_out_left) && $stable(o_out_right), "result item changed while held")

endmodule

bind lowpass_echo_audio_effect_core lec_checker u_lec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_left  (o_out_left),
    .o_out_right (o_out_right),
    .o_cfg_ready (o_cfg_ready)
);
